// ===== design/wbd_pkg.sv =====
// Shared types and constants for the waveform block decoder.
// Used by every module of the block; depends on nothing else.
package wbd_pkg;

   // Default fraction bits of the y_scale register.
   localparam int SCALE_FRAC_BITS_DEF = 32;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Datapath widths.
   localparam int LEVEL_W   = 26;   // (record << 8) + y_offset
   localparam int SCALE_W   = 32;
   localparam int PRODUCT_W = LEVEL_W + SCALE_W;
   localparam int VALUE_W   = 57;
   localparam int COUNT_W   = 30;

   // ASCII codes of the block header.
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Register indexes (byte address / 4).
   localparam logic [2:0] REG_BYTES_PER_SAMPLE = 3'd0;
   localparam logic [2:0] REG_SIGNED_SAMPLES   = 3'd1;
   localparam logic [2:0] REG_LITTLE_ENDIAN    = 3'd2;
   localparam logic [2:0] REG_DECIMATION       = 3'd3;
   localparam logic [2:0] REG_Y_SCALE          = 3'd4;
   localparam logic [2:0] REG_Y_OFFSET         = 3'd5;

   typedef enum logic [1:0] {
      ST_SAMPLE     = 2'd0,
      ST_BLOCK_END  = 2'd1,
      ST_INCOMPLETE = 2'd2,
      ST_BAD_HEADER = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_COUNT = 2'd1,
      PH_LEN   = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]          bytes_per_sample;
      logic                signed_samples;
      logic                little_endian;
      logic [15:0]         decimation_stride;
      logic signed [31:0]  y_scale;
      logic signed [23:0]  y_offset;
   } cfg_type;

   // One parsed result on its way to the scaler.
   typedef struct packed {
      status_type                 status;
      logic                       last;
      logic signed [LEVEL_W-1:0]  level;
   } parsed_type;

   // One multiplied result on its way to the output register.
   typedef struct packed {
      status_type                   status;
      logic                         last;
      logic signed [PRODUCT_W-1:0]  product;
   } product_type;

endpackage

// ===== design/wbd_csr.sv =====
// Configuration registers of the waveform block decoder, APB-style port.
// Depends on wbd_pkg.
module wbd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wbd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wbd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wbd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output wbd_pkg::cfg_type                cfg
);

   wbd_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       reg_index;
   logic             write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[wbd_pkg::CSR_ADDR_W-1:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            wbd_pkg::REG_BYTES_PER_SAMPLE: cfg_in.bytes_per_sample = csr_pwdata[1:0];
            wbd_pkg::REG_SIGNED_SAMPLES:   cfg_in.signed_samples   = csr_pwdata[0];
            wbd_pkg::REG_LITTLE_ENDIAN:    cfg_in.little_endian    = csr_pwdata[0];
            wbd_pkg::REG_DECIMATION:       cfg_in.decimation_stride = csr_pwdata[15:0];
            wbd_pkg::REG_Y_SCALE:          cfg_in.y_scale  = signed'(csr_pwdata[31:0]);
            wbd_pkg::REG_Y_OFFSET:         cfg_in.y_offset = signed'(csr_pwdata[23:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         wbd_pkg::REG_BYTES_PER_SAMPLE: csr_prdata = {30'd0, cfg_ff.bytes_per_sample};
         wbd_pkg::REG_SIGNED_SAMPLES:   csr_prdata = {31'd0, cfg_ff.signed_samples};
         wbd_pkg::REG_LITTLE_ENDIAN:    csr_prdata = {31'd0, cfg_ff.little_endian};
         wbd_pkg::REG_DECIMATION:       csr_prdata = {16'd0, cfg_ff.decimation_stride};
         wbd_pkg::REG_Y_SCALE:          csr_prdata = cfg_ff.y_scale;
         wbd_pkg::REG_Y_OFFSET:         csr_prdata = {8'd0, cfg_ff.y_offset};
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_sample  <= 2'd2;
         cfg_ff.signed_samples    <= 1'b1;
         cfg_ff.little_endian     <= 1'b0;
         cfg_ff.decimation_stride <= 16'd1;
         cfg_ff.y_scale           <= 32'sd1;
         cfg_ff.y_offset          <= 24'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/wbd_parser.sv =====
// Header parser, record assembly, decimation and level offset of the waveform block decoder.
// Registers at most one parsed result per request; depends on wbd_pkg.
module wbd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  wbd_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_end_of_message,
   output logic                 parsed_valid,
   input  logic                 parsed_ready,
   output wbd_pkg::parsed_type  parsed
);

   wbd_pkg::phase_type              phase_ff, phase_in;
   logic [3:0]                      digits_ff, digits_in;
   logic [wbd_pkg::COUNT_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [7:0]                      held_ff, held_in;
   logic                            second_ff, second_in;
   logic [15:0]                     dec_count_ff, dec_count_in;
   logic                            valid_ff, valid_in;
   wbd_pkg::parsed_type             parsed_ff, parsed_in;

   logic                            fire, emit, is_digit, complete, kept;
   logic [7:0]                      b;
   logic [15:0]                     stride, word;
   logic [16:0]                     dec_next, rec;
   logic [wbd_pkg::COUNT_W-1:0]     len_acc;
   logic [3:0]                      digits_dec;
   wbd_pkg::status_type             res_status;
   logic                            res_last;

   assign b         = req_rx_byte;
   assign req_ready = !valid_ff || parsed_ready;
   assign fire      = req_valid && req_ready;
   assign is_digit  = (b >= wbd_pkg::CHAR_ZERO) && (b <= wbd_pkg::CHAR_NINE);
   assign stride    = (cfg.decimation_stride == 16'd0) ? 16'd1 : cfg.decimation_stride;
   assign len_acc   = (bytes_left_ff << 3) + (bytes_left_ff << 1)
                      + wbd_pkg::COUNT_W'(b[3:0]);
   assign digits_dec = (digits_ff != 4'd0) ? digits_ff - 4'd1 : 4'd0;
   assign dec_next  = {1'b0, dec_count_ff} + 17'd1;
   assign word      = cfg.little_endian ? {b, held_ff} : {held_ff, b};

   always_comb begin
      phase_in      = phase_ff;
      digits_in     = digits_ff;
      bytes_left_in = bytes_left_ff;
      held_in       = held_ff;
      second_in     = second_ff;
      dec_count_in  = dec_count_ff;
      emit          = 1'b0;
      res_status    = wbd_pkg::ST_BLOCK_END;
      res_last      = 1'b0;
      complete      = 1'b0;
      kept          = 1'b0;
      rec           = '0;

      unique case (phase_ff)
         wbd_pkg::PH_HUNT: begin
            if (b == wbd_pkg::CHAR_HASH) begin
               phase_in = wbd_pkg::PH_COUNT;
               if (req_end_of_message) begin
                  emit = 1'b1; res_status = wbd_pkg::ST_INCOMPLETE; res_last = 1'b1;
                  phase_in = wbd_pkg::PH_HUNT;
               end
            end
         end
         wbd_pkg::PH_COUNT: begin
            if (!is_digit || b == wbd_pkg::CHAR_ZERO || req_end_of_message) begin
               emit     = 1'b1;
               res_last = 1'b1;
               if (!is_digit)                   res_status = wbd_pkg::ST_BAD_HEADER;
               else if (b == wbd_pkg::CHAR_ZERO) res_status = wbd_pkg::ST_BLOCK_END;
               else                             res_status = wbd_pkg::ST_INCOMPLETE;
            end
            if (is_digit && b != wbd_pkg::CHAR_ZERO) begin
               digits_in     = b[3:0];
               bytes_left_in = '0;
            end
            phase_in = (emit) ? wbd_pkg::PH_HUNT : wbd_pkg::PH_LEN;
            if (emit) second_in = 1'b0;
         end
         wbd_pkg::PH_LEN: begin
            if (!is_digit) begin
               emit = 1'b1; res_status = wbd_pkg::ST_BAD_HEADER; res_last = 1'b1;
            end else begin
               bytes_left_in = len_acc;
               digits_in     = digits_dec;
               if (digits_dec == 4'd0 && len_acc == '0) begin
                  emit = 1'b1; res_status = wbd_pkg::ST_BLOCK_END; res_last = 1'b1;
               end else begin
                  if (digits_dec == 4'd0) begin
                     phase_in     = wbd_pkg::PH_DATA;
                     second_in    = 1'b0;
                     dec_count_in = '0;
                  end
                  if (req_end_of_message) begin
                     emit = 1'b1; res_status = wbd_pkg::ST_INCOMPLETE; res_last = 1'b1;
                  end
               end
            end
            if (emit) begin
               phase_in  = wbd_pkg::PH_HUNT;
               second_in = 1'b0;
            end
         end
         wbd_pkg::PH_DATA: begin
            bytes_left_in = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : '0;
            if (!cfg.bytes_per_sample[1]) begin
               rec      = cfg.signed_samples ? {{9{b[7]}}, b} : {9'd0, b};
               complete = 1'b1;
            end else if (!second_ff) begin
               held_in   = b;
               second_in = 1'b1;
            end else begin
               rec       = cfg.signed_samples ? {word[15], word} : {1'b0, word};
               second_in = 1'b0;
               complete  = 1'b1;
            end
            if (complete) begin
               kept         = (dec_count_ff == 16'd0);
               dec_count_in = (dec_next >= {1'b0, stride}) ? 16'd0 : dec_next[15:0];
            end
            if (bytes_left_in == '0) begin
               // Block done: the last byte reports a sample or a bare end.
               phase_in   = wbd_pkg::PH_HUNT;
               second_in  = 1'b0;
               emit       = 1'b1;
               res_last   = 1'b1;
               res_status = kept ? wbd_pkg::ST_SAMPLE : wbd_pkg::ST_BLOCK_END;
            end else if (req_end_of_message) begin
               phase_in   = wbd_pkg::PH_HUNT;
               second_in  = 1'b0;
               emit       = 1'b1;
               res_last   = 1'b1;
               res_status = wbd_pkg::ST_INCOMPLETE;
            end else if (kept) begin
               emit       = 1'b1;
               res_status = wbd_pkg::ST_SAMPLE;
            end
         end
      endcase
   end

   always_comb begin
      parsed_in.status = res_status;
      parsed_in.last   = res_last;
      if (res_status == wbd_pkg::ST_SAMPLE)
         parsed_in.level = {rec[16], rec, 8'h00}
                           + {{(wbd_pkg::LEVEL_W-24){cfg.y_offset[23]}}, cfg.y_offset};
      else
         parsed_in.level = '0;
      if (fire)
         valid_in = emit;
      else
         valid_in = valid_ff && !parsed_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= wbd_pkg::PH_HUNT;
         digits_ff     <= '0;
         bytes_left_ff <= '0;
         held_ff       <= '0;
         second_ff     <= 1'b0;
         dec_count_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            phase_ff      <= phase_in;
            digits_ff     <= digits_in;
            bytes_left_ff <= bytes_left_in;
            held_ff       <= held_in;
            second_ff     <= second_in;
            dec_count_ff  <= dec_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) parsed_ff <= parsed_in;
   end

   assign parsed_valid = valid_ff;
   assign parsed       = parsed_ff;

endmodule

// ===== design/wbd_scaler.sv =====
// Multiply stage and the rounding or saturating result register of the decoder.
// Depends on wbd_pkg; SCALE_FRAC_BITS sets the rounding or saturating shift.
module wbd_scaler #(
   parameter int SCALE_FRAC_BITS = wbd_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [wbd_pkg::SCALE_W-1:0]  y_scale,
   input  logic                                parsed_valid,
   output logic                                parsed_ready,
   input  wbd_pkg::parsed_type                 parsed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [wbd_pkg::VALUE_W-1:0]  rsp_sample_value,
   output logic                                rsp_last
);

   localparam int PW    = wbd_pkg::PRODUCT_W;
   localparam int VW    = wbd_pkg::VALUE_W;
   localparam int SHIFT = SCALE_FRAC_BITS - 32;

   wbd_pkg::product_type        prod_ff, prod_in;
   logic                        prod_valid_ff, prod_valid_in;
   logic                        out_valid_ff, out_valid_in;
   wbd_pkg::status_type         out_status_ff;
   logic                        out_last_ff;
   logic signed [VW-1:0]        out_value_ff, value_scaled;
   logic                        prod_ready, out_ready;

   assign out_ready    = !out_valid_ff || rsp_ready;
   assign prod_ready   = !prod_valid_ff || out_ready;
   assign parsed_ready = prod_ready;

   always_comb begin
      prod_in.status  = parsed.status;
      prod_in.last    = parsed.last;
      prod_in.product = PW'(parsed.level) * PW'(y_scale);
   end

   // Bring the product to 40 fraction bits.
   generate
      if (SHIFT > 0) begin : g_round
         localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (SHIFT-1);
         logic signed [PW:0] biased;
         assign biased       = {prod_ff.product[PW-1], prod_ff.product} + HALF;
         assign value_scaled = VW'(biased >>> SHIFT);
      end else if (SHIFT < 0) begin : g_saturate
         localparam int K = -SHIFT;
         localparam logic signed [PW-1:0] MAG  = PW'(64'sd1 <<< (VW-1));
         localparam logic signed [PW-1:0] VMAX = MAG - PW'(1);
         localparam logic signed [PW-1:0] LIM_HI = VMAX >>> K;
         localparam logic signed [PW-1:0] LIM_LO = -(MAG >>> K);
         always_comb begin
            if (prod_ff.product > LIM_HI)
               value_scaled = VMAX[VW-1:0];
            else if (prod_ff.product < LIM_LO)
               value_scaled = {1'b1, {(VW-1){1'b0}}};
            else
               value_scaled = VW'(prod_ff.product <<< K);
         end
      end else begin : g_pass
         assign value_scaled = VW'(prod_ff.product);
      end
   endgenerate

   always_comb begin
      if (parsed_valid && prod_ready)
         prod_valid_in = 1'b1;
      else
         prod_valid_in = prod_valid_ff && !out_ready;
      if (prod_valid_ff && out_ready)
         out_valid_in = 1'b1;
      else
         out_valid_in = out_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parsed_valid && prod_ready) prod_ff <= prod_in;
      if (prod_valid_ff && out_ready) begin
         out_status_ff <= prod_ff.status;
         out_last_ff   <= prod_ff.last;
         out_value_ff  <= (prod_ff.status == wbd_pkg::ST_SAMPLE) ? value_scaled : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_sample_value = out_value_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ===== design/waveform_block_decoder.sv =====
// Definite-length block waveform decoder: one reply byte per request.
// A result passes the parser, product and output registers in that order.
// Throughput: one request per cycle; requests stall only once three results are held.
// Reset (synchronous, active high) returns parsing to the hash hunt,
// loads register defaults and empties the result pipeline.
// Depends on wbd_pkg, wbd_csr, wbd_parser and wbd_scaler.
module waveform_block_decoder #(
   parameter int SCALE_FRAC_BITS = wbd_pkg::SCALE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel: one reply byte
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                req_end_of_message,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [wbd_pkg::VALUE_W-1:0]  rsp_sample_value,
   output logic                                rsp_last,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wbd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wbd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wbd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   wbd_pkg::cfg_type     cfg;
   wbd_pkg::parsed_type  parsed;
   logic                 parsed_valid, parsed_ready;

   // Register file: record format, decimation and scaling.
   wbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stage 1: walk the header, build records, pick every stride-th one,
   // and add the level offset. Header errors and early ends close here.
   wbd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_message (req_end_of_message),
      .parsed_valid       (parsed_valid),
      .parsed_ready       (parsed_ready),
      .parsed             (parsed)
   );

   // Stages 2 and 3: multiply by y_scale, then round or saturate to the
   // output format and hold the result until it is taken.
   wbd_scaler #(
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_scaler (
      .clock            (clock),
      .reset            (reset),
      .y_scale          (cfg.y_scale),
      .parsed_valid     (parsed_valid),
      .parsed_ready     (parsed_ready),
      .parsed           (parsed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_sample_value (rsp_sample_value),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== design/wbd_checker.sv =====
// Port-level checks for the waveform block decoder, bound to the top level.
// Depends on wbd_pkg and waveform_block_decoder.
module wbd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic signed [wbd_pkg::VALUE_W-1:0]  rsp_sample_value,
   input logic                                rsp_last,
   input logic                                csr_pready
);

   // Only kept samples carry a value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != wbd_pkg::ST_SAMPLE |-> rsp_sample_value == '0)
      else $error("nonzero value on a non-sample result");

   // Every non-sample result closes a block.
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != wbd_pkg::ST_SAMPLE |-> rsp_last)
      else $error("non-sample result without last");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_sample_value) && $stable(rsp_last))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

endmodule

bind waveform_block_decoder wbd_checker u_wbd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_sample_value (rsp_sample_value),
   .rsp_last         (rsp_last),
   .csr_pready       (csr_pready)
);

// ===== tb/sv/waveform_block_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for waveform_block_decoder: drives reply bytes and checks every result
// against an in-bench decoder model, across several register settings.
// Depends on wbd_pkg and the waveform_block_decoder RTL.
module waveform_block_decoder_test;

   // Fraction bits of y_scale in the instance below (parameter left at its default).
   localparam int SCALE_FRAC = wbd_pkg::SCALE_FRAC_BITS_DEF;
   localparam int VALUE_W = wbd_pkg::VALUE_W;
   localparam longint signed VALUE_MAX = 64'sh00FF_FFFF_FFFF_FFFF;
   localparam longint signed VALUE_MIN = -64'sh0100_0000_0000_0000;

   typedef struct {
      logic [7:0] rx;
      logic       eom;
   } reply_byte;

   typedef struct {
      wbd_pkg::status_type         status;
      logic signed [VALUE_W-1:0]   value;
      logic                        last;
   } decoded_result;

   logic clock;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [7:0]                           req_rx_byte = 8'h00;
   logic                                 req_end_of_message = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [1:0]                           rsp_status;
   logic signed [VALUE_W-1:0]            rsp_sample_value;
   logic                                 rsp_last;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [wbd_pkg::CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [wbd_pkg::CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [wbd_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                 csr_pready;

   waveform_block_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Reply bytes waiting for the driver, and results the decoder model owes.
   reply_byte     reply_bytes[$];
   decoded_result predicted_results[$];

   // Shadow of the register file, kept in step with every port write.
   wbd_pkg::cfg_type   regs = '{2'd2, 1'b1, 1'b0, 16'd1, 32'sd1, 24'sd0};

   // Parser state of the model.
   wbd_pkg::phase_type parse_phase = wbd_pkg::PH_HUNT;
   logic [3:0]         digits_left = '0;
   logic [29:0]        data_left = '0;
   logic [7:0]         held_byte = '0;
   logic               in_record = 1'b0;
   logic [15:0]        keep_count = '0;

   int   errors = 0;
   int   requests_taken = 0;
   int   queued_bytes = 0;
   int   status_seen[4] = '{0, 0, 0, 0};
   int   gap_pct = 0;
   int   stall_pct = 0;
   int   gap_left = 0;
   int   stall_left = 0;
   bit   req_taken = 1'b0;

   // ---------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------

   // Scale (record*256 + y_offset) * y_scale to 40 fraction bits.
   function automatic logic signed [VALUE_W-1:0] scale_record(input logic signed [31:0] rec);
      longint signed level;
      longint signed product;
      int shift;
      level = longint'(rec) * 256 + longint'(regs.y_offset);
      product = level * longint'(regs.y_scale);
      shift = SCALE_FRAC - 32;
      if (shift > 0) begin
         // round half toward plus infinity while dropping bits
         return VALUE_W'((product + (64'sd1 <<< (shift - 1))) >>> shift);
      end
      if (shift < 0) begin
         // widen with saturation to the 57-bit range
         if (product > (VALUE_MAX >>> -shift)) return VALUE_W'(VALUE_MAX);
         if (product < -((64'sd1 <<< 56) >>> -shift)) return VALUE_W'(VALUE_MIN);
         return VALUE_W'(product <<< -shift);
      end
      return VALUE_W'(product);
   endfunction

   // Close the block: drop back to hunting and report it.
   function automatic bit close_block(input wbd_pkg::status_type code,
                                      output decoded_result res);
      parse_phase = wbd_pkg::PH_HUNT;
      in_record = 1'b0;
      res.status = code;
      res.value = '0;
      res.last = 1'b1;
      return 1'b1;
   endfunction

   // Advance the model by one reply byte; return 1 when it yields a result.
   function automatic bit decode_byte(input logic [7:0] b, input logic eom,
                                      output decoded_result res);
      logic                is_digit;
      logic signed [31:0]  rec;
      logic [15:0]         word;
      logic [15:0]         stride;
      bit                  complete;
      bit                  kept;
      is_digit = (b >= wbd_pkg::CHAR_ZERO) && (b <= wbd_pkg::CHAR_NINE);
      res.status = wbd_pkg::ST_SAMPLE;
      res.value = '0;
      res.last = 1'b0;
      rec = '0;
      complete = 1'b0;
      kept = 1'b0;
      case (parse_phase)
         wbd_pkg::PH_HUNT: begin
            if (b != wbd_pkg::CHAR_HASH) return 1'b0;
            parse_phase = wbd_pkg::PH_COUNT;
            if (eom) return close_block(wbd_pkg::ST_INCOMPLETE, res);
            return 1'b0;
         end
         wbd_pkg::PH_COUNT: begin
            if (!is_digit) return close_block(wbd_pkg::ST_BAD_HEADER, res);
            // "#0" is an empty block
            if (b == wbd_pkg::CHAR_ZERO) return close_block(wbd_pkg::ST_BLOCK_END, res);
            digits_left = 4'(b - wbd_pkg::CHAR_ZERO);
            data_left = '0;
            parse_phase = wbd_pkg::PH_LEN;
            if (eom) return close_block(wbd_pkg::ST_INCOMPLETE, res);
            return 1'b0;
         end
         wbd_pkg::PH_LEN: begin
            if (!is_digit) return close_block(wbd_pkg::ST_BAD_HEADER, res);
            data_left = 30'(data_left * 10 + (b - wbd_pkg::CHAR_ZERO));
            if (digits_left != 0) digits_left--;
            if (digits_left == 0) begin
               // all-zero length digits make an empty block
               if (data_left == 0) return close_block(wbd_pkg::ST_BLOCK_END, res);
               parse_phase = wbd_pkg::PH_DATA;
               in_record = 1'b0;
               keep_count = '0;
            end
            if (eom) return close_block(wbd_pkg::ST_INCOMPLETE, res);
            return 1'b0;
         end
         default: begin
            if (data_left != 0) data_left--;
            // bytes_per_sample 0 acts as 1, 3 acts as 2
            if (!regs.bytes_per_sample[1]) begin
               rec = regs.signed_samples ? 32'(signed'(b)) : 32'(b);
               complete = 1'b1;
            end else if (!in_record) begin
               held_byte = b;
               in_record = 1'b1;
            end else begin
               word = regs.little_endian ? {b, held_byte} : {held_byte, b};
               rec = regs.signed_samples ? 32'(signed'(word)) : 32'(word);
               in_record = 1'b0;
               complete = 1'b1;
            end
            if (complete) begin
               stride = (regs.decimation_stride == 0) ? 16'd1 : regs.decimation_stride;
               kept = (keep_count == 0);
               keep_count++;
               if (keep_count >= stride) keep_count = '0;
            end
            if (data_left == 0) begin
               // last byte of the block: a sample if kept, else a bare block end
               parse_phase = wbd_pkg::PH_HUNT;
               in_record = 1'b0;
               if (kept) begin
                  res.value = scale_record(rec);
                  res.last = 1'b1;
                  return 1'b1;
               end
               return close_block(wbd_pkg::ST_BLOCK_END, res);
            end
            // early end of the reply overrides a sample finished by this byte
            if (eom) return close_block(wbd_pkg::ST_INCOMPLETE, res);
            if (kept) begin
               res.value = scale_record(rec);
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: change inputs on the falling edge only
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      reply_byte next;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // the last request went through (or none was up): pick what comes next
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap_left = $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else if (reply_bytes.size() != 0) begin
            next = reply_bytes.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= next.rx;
            req_end_of_message <= next.eom;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Throttle the result side in random bursts.
   always @(negedge clock) begin : result_throttle
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample on the rising edge, check results, predict from requests
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      decoded_result want;
      decoded_result got;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            status_seen[rsp_status]++;
            if (predicted_results.size() == 0) begin
               $error("result with none pending: status %0d value %0d last %0b",
                      rsp_status, rsp_sample_value, rsp_last);
               errors++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_sample_value !== want.value) begin
                  $error("sample_value: expected %0d, actual %0d",
                         want.value, rsp_sample_value);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            requests_taken++;
            if (decode_byte(req_rx_byte, req_end_of_message, got))
               predicted_results.push_back(got);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic eom);
      reply_bytes.push_back('{b, eom});
      queued_bytes++;
   endtask

   // Push an ASCII string, optionally marking its last byte as end of reply.
   task automatic push_text(input string s, input logic eom_last);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], eom_last && (i == s.len() - 1));
   endtask

   // Build one random reply: some noise, then a block that is mostly well formed,
   // sometimes cut short, sometimes with a broken header.
   task automatic queue_random_reply();
      reply_byte  msg[$];
      int         kind;
      int         roll;
      int         body;
      int         ndigits;
      int         value;
      int         hash_at;
      int         cut;
      int         digs[9];
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      repeat ($urandom_range(0, 3)) begin
         b = 8'($urandom_range(0, 255));
         if (b == wbd_pkg::CHAR_HASH) b = 8'hA3;
         // an end of reply while hunting yields nothing
         msg.push_back('{b, 1'($urandom_range(0, 9) == 0)});
      end
      hash_at = msg.size();
      msg.push_back('{wbd_pkg::CHAR_HASH, 1'b0});
      ndigits = 0;
      if (kind < 5) begin
         msg.push_back('{wbd_pkg::CHAR_ZERO, 1'b0});
      end else begin
         roll = $urandom_range(0, 99);
         body = (roll < 6) ? 0 : (roll < 88) ? $urandom_range(1, 24) : $urandom_range(25, 120);
         ndigits = (body >= 100) ? 3 : (body >= 10) ? 2 : 1;
         ndigits += $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) ndigits = 9;
         value = body;
         for (int i = 0; i < ndigits; i++) begin
            digs[i] = value % 10;
            value /= 10;
         end
         msg.push_back('{8'(wbd_pkg::CHAR_ZERO + ndigits), 1'b0});
         for (int i = ndigits - 1; i >= 0; i--)
            msg.push_back('{8'(wbd_pkg::CHAR_ZERO + digs[i]), 1'b0});
         repeat (body) msg.push_back('{8'($urandom_range(0, 255)), 1'b0});
      end
      // most replies end with the block; a few run on into the next one
      if (kind < 95) msg[msg.size() - 1].eom = 1'b1;
      if (kind >= 70 && kind < 82) begin
         // reply ends before the block is complete
         cut = $urandom_range(hash_at, msg.size() - 2);
         msg[cut].eom = 1'b1;
         while (msg.size() > cut + 1) void'(msg.pop_back());
      end else if (kind >= 82 && kind < 92) begin
         // corrupt one header character and cut the message after it
         cut = $urandom_range(hash_at + 1, hash_at + 1 + ndigits);
         do b = 8'($urandom_range(0, 255));
         while (b >= wbd_pkg::CHAR_ZERO && b <= wbd_pkg::CHAR_NINE);
         msg[cut] = '{b, 1'($urandom_range(0, 1))};
         while (msg.size() > cut + 1) void'(msg.pop_back());
      end
      foreach (msg[i]) push_byte(msg[i].rx, msg[i].eom);
   endtask

   // Write one register through the port: setup cycle, then access cycle.
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (index)
         wbd_pkg::REG_BYTES_PER_SAMPLE: regs.bytes_per_sample = value[1:0];
         wbd_pkg::REG_SIGNED_SAMPLES:   regs.signed_samples = value[0];
         wbd_pkg::REG_LITTLE_ENDIAN:    regs.little_endian = value[0];
         wbd_pkg::REG_DECIMATION:       regs.decimation_stride = value[15:0];
         wbd_pkg::REG_Y_SCALE:          regs.y_scale = value;
         wbd_pkg::REG_Y_OFFSET:         regs.y_offset = value[23:0];
         default: ;
      endcase
   endtask

   // Hold until every queued request is in and every result is out,
   // then let the pipeline settle past its latency.
   task automatic wait_idle();
      while (reply_bytes.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      wbd_pkg::cfg_type setting;
      int               phase_end;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset settings (2-byte signed, high byte first).
      gap_pct = 10;
      stall_pct = 10;
      push_text("#0", 1'b1);                   // zero digit count: empty block
      push_text("#10", 1'b1);                  // all-zero length: empty block
      push_text("#Z", 1'b1);                   // non-digit count
      push_text("#1A", 1'b1);                  // non-digit length
      push_byte(8'hFF, 1'b1);                  // reply ends while hunting
      push_text("#", 1'b1);                    // reply ends on the hash itself
      push_text("#12", 1'b0);                  // most negative 16-bit record
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b1);
      push_text("#14", 1'b0);                  // ends early, overriding a finished record
      push_byte(8'h7F, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_text("#13", 1'b0);                  // odd trailing byte forms no record
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(8'h56, 1'b1);

      // Random part over several settings, extremes first; sender holds off
      // between phases until every result is back.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: setting = '{2'd1, 1'b0, 1'b0, 16'd1, 32'sh7FFF_FFFF, 24'sh7F_FFFF};
            1: setting = '{2'd2, 1'b1, 1'b1, 16'd3, 32'sh8000_0000, 24'sh80_0000};
            2: setting = '{2'd0, 1'b1, 1'b0, 16'd0, 32'($urandom), 24'($urandom)};
            3: setting = '{2'd3, 1'b0, 1'b1, 16'd65535, -32'sd1, 24'($urandom)};
            default: setting = '{2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 16'($urandom_range(1, 4)),
                                 32'($urandom), 24'($urandom)};
         endcase
         wait_idle();
         write_reg(wbd_pkg::REG_BYTES_PER_SAMPLE, 32'(setting.bytes_per_sample));
         write_reg(wbd_pkg::REG_SIGNED_SAMPLES, 32'(setting.signed_samples));
         write_reg(wbd_pkg::REG_LITTLE_ENDIAN, 32'(setting.little_endian));
         write_reg(wbd_pkg::REG_DECIMATION, 32'(setting.decimation_stride));
         write_reg(wbd_pkg::REG_Y_SCALE, setting.y_scale);
         write_reg(wbd_pkg::REG_Y_OFFSET, 32'(setting.y_offset));
         // drop all idling for the closing phase
         gap_pct = (ph == 7) ? 0 : (ph % 2 == 0) ? 15 : 30;
         stall_pct = (ph == 7) ? 0 : (ph % 3 == 0) ? 30 : 12;
         phase_end = queued_bytes + 45;
         while (queued_bytes < phase_end) queue_random_reply();
      end

      wait_idle();
      $display("Ran %0d reply bytes through 9 register settings; results seen:", requests_taken);
      $display("  %0d samples, %0d block ends, %0d cut short, %0d bad headers",
               status_seen[wbd_pkg::ST_SAMPLE], status_seen[wbd_pkg::ST_BLOCK_END],
               status_seen[wbd_pkg::ST_INCOMPLETE], status_seen[wbd_pkg::ST_BAD_HEADER]);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_400_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
design/wbd_pkg.sv
design/wbd_csr.sv
design/wbd_parser.sv
design/wbd_scaler.sv
design/waveform_block_decoder.sv
design/wbd_checker.sv
tb/sv/waveform_block_decoder_test.sv
